@@ hdl/cie_pkg.sv @@
// ----------------------------------------------------------------------------
// cie_pkg
// shared types and constants for the cbor item encoder
// ----------------------------------------------------------------------------
`default_nettype none

package cie_pkg;

  // input opcodes
  typedef enum logic [3:0] {
    OP_BEGIN   = 4'd0,
    OP_INT     = 4'd1,
    OP_ARRAY   = 4'd2,
    OP_MAP     = 4'd3,
    OP_BREAK   = 4'd4,
    OP_TEXT    = 4'd5,
    OP_BYTES   = 4'd6,
    OP_PAYLOAD = 4'd7,
    OP_F32     = 4'd8,
    OP_F64     = 4'd9,
    OP_BOOL    = 4'd10,
    OP_NULL    = 4'd11,
    OP_FINISH  = 4'd12
  } cie_op_t;

  // cbor major types
  localparam logic [2:0] MT_UINT   = 3'd0;
  localparam logic [2:0] MT_NINT   = 3'd1;
  localparam logic [2:0] MT_BYTES  = 3'd2;
  localparam logic [2:0] MT_TEXT   = 3'd3;
  localparam logic [2:0] MT_ARRAY  = 3'd4;
  localparam logic [2:0] MT_MAP    = 3'd5;
  localparam logic [2:0] MT_SIMPLE = 3'd7;

  // additional info codes
  localparam logic [4:0] INFO_U8     = 5'd24;
  localparam logic [4:0] INFO_U16    = 5'd25;
  localparam logic [4:0] INFO_U32    = 5'd26;
  localparam logic [4:0] INFO_U64    = 5'd27;
  localparam logic [4:0] INFO_INDEF  = 5'd31;
  localparam logic [4:0] INFO_FALSE  = 5'd20;
  localparam logic [4:0] INFO_TRUE   = 5'd21;
  localparam logic [4:0] INFO_NULL   = 5'd22;
  localparam logic [7:0] BREAK_BYTE  = 8'hFF;

  // register map
  localparam logic [1:0] CAP_ADDR    = 2'd0;
  localparam logic [15:0] CAP_RESET  = 16'hFFFF;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [63:0] value;
    logic               indefinite;
  } cie_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] byte_offset;
    logic        write_valid;
    logic        last;
    logic        overflowed;
    logic [15:0] frame_length;
  } cie_out_t;

  // one classified item waiting for the byte serializer
  typedef struct packed {
    logic [7:0]  head;       // initial byte
    logic [63:0] arg;        // argument, sent big endian
    logic [3:0]  nargs;      // argument bytes: 0, 1, 2, 4 or 8
    logic        wr;         // bytes are written
    logic [15:0] offset;     // frame offset of the initial byte
    logic        ovf;        // overflow flag after this item
    logic [15:0] flen;       // frame length report
  } cie_desc_t;

endpackage

`default_nettype wire

@@ hdl/cie_front.sv @@
// ----------------------------------------------------------------------------
// cie_front
// classifies one item per accepted cycle, owns byte count and overflow flag
// ----------------------------------------------------------------------------
`default_nettype none

module cie_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         capacity,
  input  cie_pkg::cie_in_t    item,
  input  logic                accept,
  output cie_pkg::cie_desc_t  desc
);

  logic [15:0] count_r, count_nxt;
  logic        ovf_r, ovf_nxt;

  logic [2:0]  major;
  logic [4:0]  info;
  logic [63:0] arg;
  logic [3:0]  nargs;
  logic        has_bytes;
  logic        raw_head;
  logic [7:0]  raw_byte;
  logic [8:0]  form;
  logic [63:0] int_mag;
  logic [4:0]  total;
  logic [16:0] end_pos;
  logic        fits;

  // shortest argument form: {info, argument bytes}
  function automatic logic [8:0] var_form(input logic [63:0] n);
    logic [8:0] f;
    if (n < 64'd24) begin
      f = {n[4:0], 4'd0};
    end else if (n <= 64'hFF) begin
      f = {cie_pkg::INFO_U8, 4'd1};
    end else if (n <= 64'hFFFF) begin
      f = {cie_pkg::INFO_U16, 4'd2};
    end else if (n <= 64'hFFFF_FFFF) begin
      f = {cie_pkg::INFO_U32, 4'd4};
    end else begin
      f = {cie_pkg::INFO_U64, 4'd8};
    end
    return f;
  endfunction

  // negatives go out as one's complement
  assign int_mag = item.value[63] ? ~item.value : item.value;

  always_comb begin
    major     = cie_pkg::MT_SIMPLE;
    info      = 5'd0;
    arg       = item.value;
    nargs     = 4'd0;
    has_bytes = 1'b1;
    raw_head  = 1'b0;
    raw_byte  = 8'd0;
    form      = var_form(item.value);
    unique case (item.opcode) inside
      cie_pkg::OP_INT: begin
        form  = var_form(int_mag);
        major = item.value[63] ? cie_pkg::MT_NINT : cie_pkg::MT_UINT;
        arg   = int_mag;
        {info, nargs} = form;
      end
      cie_pkg::OP_ARRAY, cie_pkg::OP_MAP: begin
        major = (item.opcode == cie_pkg::OP_ARRAY) ? cie_pkg::MT_ARRAY
                                                   : cie_pkg::MT_MAP;
        if (item.indefinite) begin
          info = cie_pkg::INFO_INDEF;
        end else begin
          {info, nargs} = form;
        end
      end
      cie_pkg::OP_BREAK: begin
        raw_head = 1'b1;
        raw_byte = cie_pkg::BREAK_BYTE;
      end
      cie_pkg::OP_TEXT: begin
        major = cie_pkg::MT_TEXT;
        {info, nargs} = form;
      end
      cie_pkg::OP_BYTES: begin
        major = cie_pkg::MT_BYTES;
        {info, nargs} = form;
      end
      cie_pkg::OP_PAYLOAD: begin
        raw_head = 1'b1;
        raw_byte = item.value[7:0];
      end
      cie_pkg::OP_F32: begin
        info  = cie_pkg::INFO_U32;
        arg   = {32'd0, item.value[31:0]};
        nargs = 4'd4;
      end
      cie_pkg::OP_F64: begin
        info  = cie_pkg::INFO_U64;
        nargs = 4'd8;
      end
      cie_pkg::OP_BOOL: begin
        info = (item.value != 64'd0) ? cie_pkg::INFO_TRUE : cie_pkg::INFO_FALSE;
      end
      cie_pkg::OP_NULL: begin
        info = cie_pkg::INFO_NULL;
      end
      default: begin
        has_bytes = 1'b0;
      end
    endcase
  end

  assign total   = {1'b0, nargs} + 5'd1;
  assign end_pos = {1'b0, count_r} + {12'd0, total};
  assign fits    = end_pos <= {1'b0, capacity};

  always_comb begin
    desc.head   = raw_head ? raw_byte : {major, info};
    desc.arg    = arg;
    desc.nargs  = nargs;
    desc.wr     = has_bytes && !ovf_r && fits;
    desc.offset = count_r;
    desc.ovf    = ovf_r;
    desc.flen   = 16'd0;
    count_nxt   = count_r;
    ovf_nxt     = ovf_r;
    if (item.opcode == cie_pkg::OP_BEGIN) begin
      desc.ovf  = 1'b0;
      count_nxt = 16'd0;
      ovf_nxt   = 1'b0;
    end else if (item.opcode == cie_pkg::OP_FINISH) begin
      desc.flen = ovf_r ? 16'd0 : count_r;
    end else if (has_bytes && !ovf_r) begin
      if (fits) begin
        count_nxt = end_pos[15:0];
      end else begin
        desc.ovf = 1'b1;
        ovf_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 16'd0;
      ovf_r   <= 1'b0;
    end else if (accept) begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/cie_fifo.sv @@
// ----------------------------------------------------------------------------
// cie_fifo
// small descriptor queue between classifier and serializer
// ----------------------------------------------------------------------------
`default_nettype none

module cie_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  cie_pkg::cie_desc_t  wr_data,
  output logic                full,
  input  logic                rd_en,
  output cie_pkg::cie_desc_t  rd_data,
  output logic                rd_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cie_pkg::cie_desc_t mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full     = cnt_r == FULL_CNT;
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wp_nxt  = do_wr ? ((wp_r == LAST_PTR) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = do_rd ? ((rp_r == LAST_PTR) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  // occupancy bookkeeping
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("queue count beyond depth");

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    do_wr && !do_rd |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count did not grow on write");

endmodule

`default_nettype wire

@@ hdl/cie_back.sv @@
// ----------------------------------------------------------------------------
// cie_back
// serializes descriptors to words, one per cycle while output free or popped
// ----------------------------------------------------------------------------
`default_nettype none

module cie_back (
  input  logic                clk,
  input  logic                rst_n,
  input  cie_pkg::cie_desc_t  desc,
  input  logic                desc_valid,
  output logic                desc_pop,
  output cie_pkg::cie_out_t   out_word,
  output logic                out_valid,
  input  logic                out_pop
);

  logic [3:0]  idx_r, idx_nxt;
  logic        valid_r, valid_nxt;
  cie_pkg::cie_out_t word_r, word_nxt;
  logic [3:0]  nres;
  logic        is_last;
  logic        load;
  logic [2:0]  sel;
  logic [3:0]  pos;

  assign nres    = desc.wr ? desc.nargs + 4'd1 : 4'd1;
  assign is_last = idx_r == nres - 4'd1;
  assign load    = desc_valid && (!valid_r || out_pop);
  assign pos     = desc.nargs - idx_r;
  assign sel     = pos[2:0];

  always_comb begin
    word_nxt.out_byte     = 8'd0;
    word_nxt.byte_offset  = 16'd0;
    word_nxt.write_valid  = desc.wr;
    word_nxt.last         = is_last;
    word_nxt.overflowed   = desc.ovf;
    word_nxt.frame_length = desc.flen;
    if (desc.wr) begin
      word_nxt.out_byte    = (idx_r == 4'd0) ? desc.head : desc.arg[8*sel +: 8];
      word_nxt.byte_offset = desc.offset + {12'd0, idx_r};
    end
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = is_last ? 4'd0 : idx_r + 4'd1;
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
  end

  assign desc_pop  = load && is_last;
  assign out_word  = word_r;
  assign out_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 4'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= word_nxt;
    end
  end

  // at most nine words per item
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= 4'd8)
    else $error("serializer index out of range");

  // dropped items produce a single closing word
  a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !word_r.write_valid |-> word_r.last)
    else $error("non-write word not marked last");

  // index returns to zero once the final word of an item is loaded
  a_idx_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    load && is_last |=> idx_r == 4'd0)
    else $error("serializer index not cleared after last word");

endmodule

`default_nettype wire

@@ hdl/cbor_item_encoder.sv @@
// ----------------------------------------------------------------------------
// cbor_item_encoder
// cbor item encoder with frame byte count and sticky overflow
// ----------------------------------------------------------------------------
// The front end takes one item per cycle while the descriptor queue has
// room (full low), works out the cbor initial byte, the shortest argument
// form and the fit against capacity, and updates the frame byte count and
// overflow flag right away. The back end turns each queued descriptor into
// result words, one word per cycle while the output is free or popped: an
// item that writes n bytes (one to nine) gives n words, and every other item
// gives one word. A result passes through the descriptor queue and the
// output register. Sustained rate is one item per cycle for single-byte
// items while pop stays high; the one-byte-per-cycle serializer limits long
// headers, and the input stalls only when QUEUE_DEPTH descriptors are
// waiting. No clearing pass after reset. Capacity lives at address 0 of the
// register port and should be written while the block is idle.
`default_nettype none

module cbor_item_encoder #(
  parameter int QUEUE_DEPTH = 4    // descriptors between front and back
) (
  input  logic                clk,
  input  logic                rst_n,
  // input queue side
  input  logic                push,
  output logic                full,
  input  cie_pkg::cie_in_t    in_item,
  // result queue side
  output logic                empty,
  input  logic                pop,
  output cie_pkg::cie_out_t   out_item,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [15:0]        capacity_r;
  logic               accept;
  cie_pkg::cie_desc_t fr_desc;
  cie_pkg::cie_desc_t q_desc;
  logic               q_valid;
  logic               q_pop;
  logic               q_full;
  logic               out_valid;

  // register port: pready is tied high
  assign pready = 1'b1;
  assign prdata = (paddr == cie_pkg::CAP_ADDR) ? {16'd0, capacity_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= cie_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == cie_pkg::CAP_ADDR)) begin
      capacity_r <= pwdata[15:0];
    end
  end

  // a word is taken whenever the queue has a free slot
  assign full   = q_full;
  assign accept = push && !q_full;

  // classify and account
  cie_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .capacity (capacity_r),
    .item     (in_item),
    .accept   (accept),
    .desc     (fr_desc)
  );

  // decouple classification from byte emission
  cie_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (accept),
    .wr_data  (fr_desc),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_data  (q_desc),
    .rd_valid (q_valid)
  );

  // one encoded byte per cycle into the output register while free or popped
  cie_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc       (q_desc),
    .desc_valid (q_valid),
    .desc_pop   (q_pop),
    .out_word   (out_item),
    .out_valid  (out_valid),
    .out_pop    (pop)
  );

  assign empty = !out_valid;

  // a written byte never lands past the configured capacity at write time
  a_wr_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_item.write_valid |-> !out_item.overflowed)
    else $error("written byte carries overflow flag");

  // frame length is reported only on a single closing word
  a_flen_single: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && (out_item.frame_length != 16'd0) |->
      out_item.last && !out_item.write_valid)
    else $error("frame length on a data word");

  // capacity write takes effect on the next cycle
  a_cap_write: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && (paddr == cie_pkg::CAP_ADDR) |=>
      capacity_r == $past(pwdata[15:0]))
    else $error("capacity register not updated");

endmodule

`default_nettype wire
